// File: hw/rtl/kmdh_pkg.sv
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Matrix size, configuration reset values and register indices, key phase and
// event codes, and the per-key state entry.
package kmdh_pkg;

    localparam int ROWS  = 8;
    localparam int COLS  = 16;
    localparam int KEYS  = ROWS * COLS;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int DEPTH = 2 ** KEY_W;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] HOLD_RESET     = 16'd500;

    localparam logic [3:0] REG_DEBOUNCE = 4'd0;
    localparam logic [3:0] REG_HOLD     = 4'd1;

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_TRIGGERED = 2'd1,
        PH_PRESSED   = 2'd2,
        PH_HELD      = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } t_event;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] last_ms;
    } t_entry;

endpackage

// File: hw/rtl/key_matrix_debounce_hold.sv
// ----------------------------------------------------------------------------
// Key matrix debounce and hold detection
// Per-key phase tracking with debounce and hold timing, one sample per cycle when not stalled.
// ----------------------------------------------------------------------------
// Each accepted transaction is one sample of one key and yields exactly one
// result transaction, registered through the sample stage and then the output
// register, at a sustained rate of one sample per cycle when the output is not
// stalled. Key phase and last-change time live in a single-port-write,
// registered-read memory; a sample of the key updated in the cycle before it
// takes the new entry from a bypass register. Reset clears one valid flag per
// key, so the block accepts samples straight out of reset. Configuration
// writes are always ready and take effect on the following sample.
module key_matrix_debounce_hold
    import kmdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_key_row,
    input  logic [3:0]  i_key_col,
    input  logic        i_key_active,
    input  logic [31:0] i_now_ms,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_row,
    output logic [3:0]  o_event_col,
    output logic [1:0]  o_key_event,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_key_vld;

    logic [15:0]        r_debounce;
    logic [15:0]        r_hold;

    logic               r_s1_valid;
    logic [2:0]         r_s1_row;
    logic [3:0]         r_s1_col;
    logic               r_s1_active;
    logic [31:0]        r_s1_now;
    logic               r_s1_in_range;
    logic [KEY_W-1:0]   r_s1_idx;
    t_entry             r_rd_entry;
    logic               r_rd_vld;
    logic               r_fwd;
    t_entry             r_fwd_entry;

    logic               r_out_valid;
    logic [2:0]         r_out_row;
    logic [3:0]         r_out_col;
    t_event             r_out_event;

    logic               w_accept;
    logic               w_s1_adv;
    logic               w_write;
    logic               w_in_range;
    logic [KEY_W-1:0]   w_in_idx;
    t_entry             w_cur;
    logic [31:0]        w_elapsed;
    t_phase             n_phase;
    t_event             n_event;
    t_entry             n_entry;

    assign o_cfg_ready = 1'b1;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !w_s1_adv;
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (int'(i_key_row) < ROWS) && (int'(i_key_col) < COLS);
    assign w_in_idx   = KEY_W'(int'(i_key_row) * COLS + int'(i_key_col));

    always_comb begin
        if (r_fwd) begin
            w_cur = r_fwd_entry;
        end else if (r_rd_vld) begin
            w_cur = r_rd_entry;
        end else begin
            w_cur.phase   = PH_RELEASED;
            w_cur.last_ms = '0;
        end

        w_elapsed = r_s1_now - w_cur.last_ms;
        n_phase   = w_cur.phase;
        n_event   = EV_NONE;

        if (r_s1_in_range && (w_elapsed >= 32'(r_debounce))) begin
            if (r_s1_active) begin
                unique case (w_cur.phase)
                    PH_RELEASED: begin
                        n_phase = PH_TRIGGERED;
                    end
                    PH_TRIGGERED: begin
                        n_phase = PH_PRESSED;
                        n_event = EV_PRESSED;
                    end
                    PH_PRESSED: begin
                        if (w_elapsed > 32'(r_hold)) begin
                            n_phase = PH_HELD;
                            n_event = EV_HELD;
                        end
                    end
                    PH_HELD: begin
                        n_phase = PH_HELD;
                    end
                endcase
            end else if (w_cur.phase != PH_RELEASED) begin
                if (w_cur.phase != PH_TRIGGERED) begin
                    n_event = EV_RELEASED;
                end
                n_phase = PH_RELEASED;
            end
        end

        n_entry.phase   = n_phase;
        n_entry.last_ms = r_s1_now;
        w_write         = w_s1_adv && (n_phase != w_cur.phase);
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_s1_idx] <= n_entry;
        end
        if (w_accept) begin
            r_rd_entry  <= r_mem[w_in_idx];
            r_fwd_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld  <= '0;
            r_debounce <= DEBOUNCE_RESET;
            r_hold     <= HOLD_RESET;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_write) begin
                r_key_vld[r_s1_idx] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: r_debounce <= i_cfg_data;
                    REG_HOLD:     r_hold     <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row      <= i_key_row;
            r_s1_col      <= i_key_col;
            r_s1_active   <= i_key_active;
            r_s1_now      <= i_now_ms;
            r_s1_in_range <= w_in_range;
            r_s1_idx      <= w_in_idx;
            r_rd_vld      <= r_key_vld[w_in_idx];
            r_fwd         <= w_write && (w_in_idx == r_s1_idx);
        end
        if (w_s1_adv) begin
            r_out_row   <= r_s1_row;
            r_out_col   <= r_s1_col;
            r_out_event <= n_event;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_event_row = r_out_row;
    assign o_event_col = r_out_col;
    assign o_key_event = r_out_event;

endmodule
